// ----- rtl/b32_pkg.sv -----
`default_nettype none

package b32_pkg;

   localparam int PREFIX_MAX = 8;
   localparam int PLEN_W     = 4;
   localparam int CNT_W      = 3;
   localparam int CHK_W      = 30;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_CHARS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LENGTH = 1'd1;

   localparam logic [63:0]       PREFIX_CHARS_RESET  = 64'd25442;
   localparam logic [PLEN_W-1:0] PREFIX_LENGTH_RESET = 4'd2;

   localparam logic [CHK_W-1:0] GEN0 = 30'h3b6a57b2;
   localparam logic [CHK_W-1:0] GEN1 = 30'h26508e6d;
   localparam logic [CHK_W-1:0] GEN2 = 30'h1ea119fa;
   localparam logic [CHK_W-1:0] GEN3 = 30'h3d4233dd;
   localparam logic [CHK_W-1:0] GEN4 = 30'h2a1462b3;
   localparam logic [CHK_W-1:0] BECH32M_CONST = 30'h2bc830a3;
   localparam logic [CHK_W-1:0] BECH32_CONST  = 30'd1;
   localparam logic [CHK_W-1:0] CHK_INIT_VAL  = 30'd1;

   localparam logic [CNT_W-1:0] CHK_LAST = 3'd5;
   localparam logic [4:0]       VER_MAX  = 5'd16;
   localparam logic [7:0]       CHAR_MIN = 8'd33;
   localparam logic [7:0]       CHAR_MAX = 8'd126;
   localparam logic [7:0]       UPPER_A  = 8'h41;
   localparam logic [7:0]       UPPER_Z  = 8'h5A;
   localparam logic [6:0]       SEP_CHAR = 7'h31;

   localparam logic [7:0] CHARSET [32] = '{
      "q", "p", "z", "r", "y", "9", "x", "8",
      "g", "f", "2", "t", "v", "d", "w", "0",
      "s", "3", "j", "n", "5", "4", "k", "h",
      "c", "e", "6", "m", "u", "a", "7", "l"
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HASH_HI,
      ST_HASH_ZERO,
      ST_PREFIX,
      ST_SEP,
      ST_VER,
      ST_GROUP,
      ST_PAD,
      ST_CHK_PM,
      ST_CHK_OUT,
      ST_ERR
   } state_type;

   typedef enum logic [3:0] {
      CHK_HOLD,
      CHK_INIT,
      CHK_HI,
      CHK_PM,
      CHK_LO,
      CHK_VER,
      CHK_GROUP,
      CHK_PAD,
      CHK_FINAL,
      CHK_SHIFT
   } chk_op_type;

   typedef enum logic [2:0] {
      OUT_PREFIX,
      OUT_SEP,
      OUT_VER,
      OUT_GROUP,
      OUT_PAD,
      OUT_CHK,
      OUT_ERR
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        start;
      logic        discard_step;
      logic        fail;
      logic        clear_addr;
      logic        group_step;
      logic        cnt_clr;
      logic        cnt_inc;
      chk_op_type  chk_op;
      logic        emit;
      out_sel_type out_sel;
      logic        run_end;
      logic        addr_end;
   } dp_cmd_type;

   typedef struct packed {
      logic discarding;
      logic in_address;
      logic first_bad;
      logic too_many;
      logic prefix_last;
      logic chk_last;
      logic group_last;
      logic group_rem_zero;
      logic fin;
      logic out_free;
   } dp_stat_type;

   // one polymod step: shift in a zero group
   function automatic logic [CHK_W-1:0] pm(input logic [CHK_W-1:0] c);
      logic [4:0]       top;
      logic [CHK_W-1:0] r;
      top = c[29:25];
      r   = {c[24:0], 5'b00000};
      if (top[0]) r = r ^ GEN0;
      if (top[1]) r = r ^ GEN1;
      if (top[2]) r = r ^ GEN2;
      if (top[3]) r = r ^ GEN3;
      if (top[4]) r = r ^ GEN4;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bech32_address_encoder.sv -----
// Segwit address encoder (bech32 / bech32m), one payload byte per request.
// req_* carries one byte, the witness version (sampled on the first byte of an
// address) and a final flag on the last byte. rsp_* returns the address string
// one character per transaction; run_end marks the last character a request
// produced, address_end the last checksum character or an error result.
// csr_* writes the prefix characters (index 0) and prefix length (index 1); it
// is always ready and should only be written between addresses.
// One request is worked on at a time, one polymod step per cycle through the
// single checksum register unless a state waits for the output register. A middle
// byte is accepted and then emits one character per 5-bit group. The first byte
// adds prefix hashing and emission of the prefix, separator and version, the
// final byte adds the pad group if any, six checksum rounds and six checksum characters.
// A single output register holds the next character; when the receiver stalls
// the sequencer waits at that character; a request is only accepted when idle.
// Synchronous reset clears the address state and the output valid flag and loads the
// default prefix "bc"; no clearing pass is needed.
`default_nettype none

module bech32_address_encoder #(
   parameter int MAX_BYTES = 40
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_data_byte,
   input  wire  [4:0] req_witness_version,
   input  wire        req_final_byte,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_run_end,
   output logic       rsp_address_end,
   output logic       rsp_error,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [b32_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [63:0] csr_data
);
   import b32_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   b32_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   b32_dp #(
      .MAX_BYTES (MAX_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_data_byte       (req_data_byte),
      .req_witness_version (req_witness_version),
      .req_final_byte      (req_final_byte),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_out_char        (rsp_out_char),
      .rsp_run_end         (rsp_run_end),
      .rsp_address_end     (rsp_address_end),
      .rsp_error           (rsp_error),
      .cmd                 (cmd),
      .stat                (stat)
   );

`ifndef ASSERT_OFF
   // a new character never overwrites one the receiver has not taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_char == 7'd0 && rsp_address_end && rsp_run_end)
      else $error("malformed error result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_end |-> rsp_run_end)
      else $error("address end without run end");

   // one request in flight at a time; a swallowed byte finishes at its accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !stat.discarding |=> !req_ready)
      else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/b32_ctrl.sv -----
`default_nettype none

module b32_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  b32_pkg::dp_stat_type stat,
   output b32_pkg::dp_cmd_type  cmd
);
   import b32_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.chk_op  = CHK_HOLD;
      cmd.out_sel = OUT_ERR;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (stat.discarding) begin
                  cmd.discard_step = 1'b1;
               end else if (!stat.in_address) begin
                  cmd.load = 1'b1;
                  if (stat.first_bad) begin
                     state_in = ST_ERR;
                  end else begin
                     cmd.start   = 1'b1;
                     cmd.chk_op  = CHK_INIT;
                     cmd.cnt_clr = 1'b1;
                     state_in    = ST_HASH_HI;
                  end
               end else begin
                  cmd.load = 1'b1;
                  state_in = stat.too_many ? ST_ERR : ST_GROUP;
               end
            end
         end
         ST_HASH_HI: begin
            cmd.chk_op = CHK_HI;
            if (stat.prefix_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_HASH_ZERO;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_HASH_ZERO: begin
            cmd.chk_op = CHK_PM;
            state_in   = ST_PREFIX;
         end
         ST_PREFIX: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_PREFIX;
               cmd.chk_op  = CHK_LO;
               if (stat.prefix_last) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_SEP;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         ST_SEP: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_SEP;
               state_in    = ST_VER;
            end
         end
         ST_VER: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_VER;
               cmd.chk_op  = CHK_VER;
               state_in    = ST_GROUP;
            end
         end
         ST_GROUP: begin
            if (stat.out_free) begin
               cmd.emit       = 1'b1;
               cmd.out_sel    = OUT_GROUP;
               cmd.chk_op     = CHK_GROUP;
               cmd.group_step = 1'b1;
               if (stat.group_last) begin
                  if (!stat.fin) begin
                     cmd.run_end = 1'b1;
                     state_in    = ST_IDLE;
                  end else if (stat.group_rem_zero) begin
                     cmd.cnt_clr = 1'b1;
                     state_in    = ST_CHK_PM;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_PAD;
               cmd.chk_op  = CHK_PAD;
               cmd.cnt_clr = 1'b1;
               state_in    = ST_CHK_PM;
            end
         end
         ST_CHK_PM: begin
            // six zero groups, final constant folded into the last step
            if (stat.chk_last) begin
               cmd.chk_op  = CHK_FINAL;
               cmd.cnt_clr = 1'b1;
               state_in    = ST_CHK_OUT;
            end else begin
               cmd.chk_op  = CHK_PM;
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_CHK_OUT: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_CHK;
               cmd.chk_op  = CHK_SHIFT;
               cmd.cnt_inc = 1'b1;
               if (stat.chk_last) begin
                  cmd.run_end    = 1'b1;
                  cmd.addr_end   = 1'b1;
                  cmd.clear_addr = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.out_sel  = OUT_ERR;
               cmd.run_end  = 1'b1;
               cmd.addr_end = 1'b1;
               cmd.fail     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/b32_dp.sv -----
`default_nettype none

module b32_dp #(
   parameter int MAX_BYTES = 40
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire  [7:0]                  req_data_byte,
   input  wire  [4:0]                  req_witness_version,
   input  wire                         req_final_byte,
   input  wire                         csr_valid,
   input  wire  [b32_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [63:0]                 csr_data,
   input  wire                         rsp_ready,
   output logic                        rsp_valid,
   output logic [6:0]                  rsp_out_char,
   output logic                        rsp_run_end,
   output logic                        rsp_address_end,
   output logic                        rsp_error,
   input  b32_pkg::dp_cmd_type         cmd,
   output b32_pkg::dp_stat_type        stat
);
   import b32_pkg::*;

   localparam int BC_W = $clog2(MAX_BYTES + 1);

   logic [63:0]       prefix_chars_ff;
   logic [PLEN_W-1:0] prefix_length_ff;
   logic [CHK_W-1:0]  chk_ff, chk_in;
   logic [3:0]        bit_store_ff;
   logic [2:0]        bit_count_ff;
   logic [BC_W-1:0]   byte_count_ff;
   logic              in_address_ff;
   logic              discarding_ff;
   logic              bech32m_ff;
   logic [11:0]       acc_ff;
   logic [3:0]        bits_ff;
   logic [4:0]        ver_ff;
   logic              fin_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rsp_valid_ff;
   logic [6:0]        rsp_char_ff;
   logic              rsp_run_end_ff;
   logic              rsp_addr_end_ff;
   logic              rsp_error_ff;

   logic [PLEN_W-1:0] plen_eff;
   logic [7:0]        pchar;
   logic [3:0]        shamt;
   logic [4:0]        grp;
   logic [4:0]        pad;
   logic [2:0]        new_bits;
   logic [3:0]        keep_mask;
   logic              prefix_bad;
   logic [6:0]        char_sel;

   assign plen_eff = (prefix_length_ff > PLEN_W'(PREFIX_MAX)) ? PLEN_W'(PREFIX_MAX)
                                                               : prefix_length_ff;
   assign pchar     = prefix_chars_ff[{cnt_ff, 3'b000} +: 8];
   assign shamt     = bits_ff - 4'd5;
   assign grp       = 5'(acc_ff >> shamt);
   assign new_bits  = shamt[2:0];
   assign keep_mask = (4'd1 << new_bits) - 4'd1;
   assign pad       = {1'b0, bit_store_ff} << (3'd5 - bit_count_ff);

   always_comb begin
      logic [7:0] ch;
      ch         = '0;
      prefix_bad = 1'b0;
      for (int i = 0; i < PREFIX_MAX; i++) begin
         ch = prefix_chars_ff[8*i +: 8];
         if (PLEN_W'(i) < plen_eff) begin
            if (ch < CHAR_MIN || ch > CHAR_MAX || (ch >= UPPER_A && ch <= UPPER_Z)) begin
               prefix_bad = 1'b1;
            end
         end
      end
   end

   assign stat.discarding     = discarding_ff;
   assign stat.in_address     = in_address_ff;
   assign stat.first_bad      = prefix_bad || (prefix_length_ff == '0) ||
                                (req_witness_version > VER_MAX) || req_final_byte;
   assign stat.too_many       = byte_count_ff >= BC_W'(MAX_BYTES);
   assign stat.prefix_last    = {1'b0, cnt_ff} == (plen_eff - 4'd1);
   assign stat.chk_last       = cnt_ff == CHK_LAST;
   assign stat.group_last     = bits_ff < 4'd10;
   assign stat.group_rem_zero = bits_ff == 4'd5;
   assign stat.fin            = fin_ff;
   assign stat.out_free       = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_chars_ff  <= PREFIX_CHARS_RESET;
         prefix_length_ff <= PREFIX_LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PREFIX_CHARS:  prefix_chars_ff  <= csr_data;
            CSR_PREFIX_LENGTH: prefix_length_ff <= csr_data[PLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      chk_in = chk_ff;
      if (cmd.clear_addr || cmd.fail) begin
         chk_in = CHK_INIT_VAL;
      end else begin
         case (cmd.chk_op)
            CHK_HOLD:  chk_in = chk_ff;
            CHK_INIT:  chk_in = CHK_INIT_VAL;
            CHK_HI:    chk_in = pm(chk_ff) ^ CHK_W'(pchar[7:5]);
            CHK_PM:    chk_in = pm(chk_ff);
            CHK_LO:    chk_in = pm(chk_ff) ^ CHK_W'(pchar[4:0]);
            CHK_VER:   chk_in = pm(chk_ff) ^ CHK_W'(ver_ff);
            CHK_GROUP: chk_in = pm(chk_ff) ^ CHK_W'(grp);
            CHK_PAD:   chk_in = pm(chk_ff) ^ CHK_W'(pad);
            CHK_FINAL: chk_in = pm(chk_ff) ^ (bech32m_ff ? BECH32M_CONST : BECH32_CONST);
            CHK_SHIFT: chk_in = {chk_ff[24:0], 5'b00000};
            default:   chk_in = chk_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff        <= CHK_INIT_VAL;
         bit_store_ff  <= '0;
         bit_count_ff  <= '0;
         byte_count_ff <= '0;
         in_address_ff <= 1'b0;
         discarding_ff <= 1'b0;
         bech32m_ff    <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         chk_ff <= chk_in;
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
         if (cmd.discard_step && req_final_byte) begin
            discarding_ff <= 1'b0;
         end
         if (cmd.start) begin
            in_address_ff <= 1'b1;
            bech32m_ff    <= req_witness_version != 5'd0;
         end
         // last group of the byte leaves the remainder bits behind
         if (cmd.group_step && stat.group_last) begin
            bit_store_ff  <= acc_ff[3:0] & keep_mask;
            bit_count_ff  <= new_bits;
            byte_count_ff <= byte_count_ff + 1'b1;
         end
         if (cmd.clear_addr || cmd.fail) begin
            bit_store_ff  <= '0;
            bit_count_ff  <= '0;
            byte_count_ff <= '0;
            in_address_ff <= 1'b0;
            bech32m_ff    <= 1'b0;
         end
         if (cmd.fail) begin
            discarding_ff <= !fin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff  <= {bit_store_ff, req_data_byte};
         bits_ff <= {1'b0, bit_count_ff} + 4'd8;
         ver_ff  <= req_witness_version;
         fin_ff  <= req_final_byte;
      end else if (cmd.group_step) begin
         bits_ff <= shamt;
      end
   end

   always_comb begin
      case (cmd.out_sel)
         OUT_PREFIX: char_sel = pchar[6:0];
         OUT_SEP:    char_sel = SEP_CHAR;
         OUT_VER:    char_sel = CHARSET[ver_ff][6:0];
         OUT_GROUP:  char_sel = CHARSET[grp][6:0];
         OUT_PAD:    char_sel = CHARSET[pad][6:0];
         OUT_CHK:    char_sel = CHARSET[chk_ff[29:25]][6:0];
         OUT_ERR:    char_sel = '0;
         default:    char_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff     <= char_sel;
         rsp_run_end_ff  <= cmd.run_end;
         rsp_addr_end_ff <= cmd.addr_end;
         rsp_error_ff    <= cmd.out_sel == OUT_ERR;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_run_end     = rsp_run_end_ff;
   assign rsp_address_end = rsp_addr_end_ff;
   assign rsp_error       = rsp_error_ff;

endmodule

`default_nettype wire
